>>> design/pdird_pkg.sv
// ----------------------------------------------------------------------------
// pdird_pkg
// Shared types, constants and helpers of the pulse-distance IR decoder.
// ----------------------------------------------------------------------------
package pdird_pkg;

   localparam int DUR_W = 16;
   localparam int CMD_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HDR_SPACE_MIN  = 3'd0,
      CSR_HDR_SPACE_MAX  = 3'd1,
      CSR_BIT_MARK_MIN   = 3'd2,
      CSR_BIT_MARK_MAX   = 3'd3,
      CSR_ONE_SPACE_MIN  = 3'd4,
      CSR_ONE_SPACE_MAX  = 3'd5,
      CSR_ZERO_SPACE_MIN = 3'd6,
      CSR_ZERO_SPACE_MAX = 3'd7
   } pdird_csr_index_type;

   localparam logic [DUR_W-1:0] RST_HDR_SPACE_MIN  = 16'd53;
   localparam logic [DUR_W-1:0] RST_HDR_SPACE_MAX  = 16'd89;
   localparam logic [DUR_W-1:0] RST_BIT_MARK_MIN   = 16'd13;
   localparam logic [DUR_W-1:0] RST_BIT_MARK_MAX   = 16'd23;
   localparam logic [DUR_W-1:0] RST_ONE_SPACE_MIN  = 16'd51;
   localparam logic [DUR_W-1:0] RST_ONE_SPACE_MAX  = 16'd87;
   localparam logic [DUR_W-1:0] RST_ZERO_SPACE_MIN = 16'd12;
   localparam logic [DUR_W-1:0] RST_ZERO_SPACE_MAX = 16'd22;

   localparam logic [CMD_W-1:0] SHIFT_RESET = 8'd1;

   typedef struct packed {
      logic [DUR_W-1:0] hdr_space_min;
      logic [DUR_W-1:0] hdr_space_max;
      logic [DUR_W-1:0] bit_mark_min;
      logic [DUR_W-1:0] bit_mark_max;
      logic [DUR_W-1:0] one_space_min;
      logic [DUR_W-1:0] one_space_max;
      logic [DUR_W-1:0] zero_space_min;
      logic [DUR_W-1:0] zero_space_max;
   } pdird_windows_type;

   typedef struct packed {
      logic [DUR_W-1:0] duration;
      logic             frame_start;
      logic             frame_end;
   } pdird_item_type;

   function automatic logic in_window(input logic [DUR_W-1:0] d,
                                      input logic [DUR_W-1:0] lo,
                                      input logic [DUR_W-1:0] hi);
      return (d >= lo) && (d <= hi);
   endfunction

endpackage

>>> design/pdird_csr.sv
// ----------------------------------------------------------------------------
// pdird_csr
// Timing window registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pdird_csr
   import pdird_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output pdird_windows_type     windows
);

   pdird_windows_type win_ff;
   pdird_windows_type win_in;

   always_comb begin
      win_in = win_ff;
      if (csr_we) begin
         case (pdird_csr_index_type'(csr_index))
            CSR_HDR_SPACE_MIN:  win_in.hdr_space_min  = csr_wdata;
            CSR_HDR_SPACE_MAX:  win_in.hdr_space_max  = csr_wdata;
            CSR_BIT_MARK_MIN:   win_in.bit_mark_min   = csr_wdata;
            CSR_BIT_MARK_MAX:   win_in.bit_mark_max   = csr_wdata;
            CSR_ONE_SPACE_MIN:  win_in.one_space_min  = csr_wdata;
            CSR_ONE_SPACE_MAX:  win_in.one_space_max  = csr_wdata;
            CSR_ZERO_SPACE_MIN: win_in.zero_space_min = csr_wdata;
            CSR_ZERO_SPACE_MAX: win_in.zero_space_max = csr_wdata;
            default:            win_in = win_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.hdr_space_min  <= RST_HDR_SPACE_MIN;
         win_ff.hdr_space_max  <= RST_HDR_SPACE_MAX;
         win_ff.bit_mark_min   <= RST_BIT_MARK_MIN;
         win_ff.bit_mark_max   <= RST_BIT_MARK_MAX;
         win_ff.one_space_min  <= RST_ONE_SPACE_MIN;
         win_ff.one_space_max  <= RST_ONE_SPACE_MAX;
         win_ff.zero_space_min <= RST_ZERO_SPACE_MIN;
         win_ff.zero_space_max <= RST_ZERO_SPACE_MAX;
      end else begin
         win_ff <= win_in;
      end
   end

   assign windows = win_ff;

endmodule

>>> design/pdird_input_stage.sv
// ----------------------------------------------------------------------------
// pdird_input_stage
// Input register that holds one accepted item until the decoder takes it.
// ----------------------------------------------------------------------------
module pdird_input_stage
   import pdird_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [DUR_W-1:0] req_duration,
   input  logic             req_frame_start,
   input  logic             req_frame_end,
   input  logic             advance,
   output logic             item_valid,
   output pdird_item_type   item
);

   logic           valid_ff;
   logic           valid_in;
   pdird_item_type item_ff;
   logic           accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.duration    <= req_duration;
         item_ff.frame_start <= req_frame_start;
         item_ff.frame_end   <= req_frame_end;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/pdird_core.sv
// ----------------------------------------------------------------------------
// pdird_core
// Frame state, window checks, bit shifting and the result register.
// ----------------------------------------------------------------------------
module pdird_core
   import pdird_pkg::*;
#(
   parameter int NUM_BITS = 8
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  pdird_item_type    item,
   input  pdird_windows_type windows,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_decoded_ok,
   output logic [CMD_W-1:0]  rsp_command
);

   localparam int FRAME_MIN = 2 * NUM_BITS + 2;
   localparam int CNT_W     = $clog2(FRAME_MIN + 1);
   localparam logic [CNT_W-1:0] CNT_FRAME_MIN = CNT_W'(FRAME_MIN);
   localparam logic [CNT_W-1:0] CNT_LAST_CHK  = CNT_W'(2 * NUM_BITS);
   localparam logic [CNT_W-1:0] CNT_HDR_SPACE = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_FIRST_BIT = CNT_W'(3);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CMD_W-1:0] shift_ff, shift_in;
   logic             err_ff, err_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_ok_ff;
   logic [CMD_W-1:0] out_cmd_ff;

   logic [CNT_W-1:0] cnt_cur;
   logic [CMD_W-1:0] shift_cur, shift_new;
   logic             err_cur, err_new;
   logic [CNT_W-1:0] cnt_new;
   logic             ok_new;
   logic             out_free;
   logic             emit;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance  = item_valid && (!item.frame_end || out_free);
   assign emit     = advance && item.frame_end;

   always_comb begin
      cnt_cur   = item.frame_start ? '0 : cnt_ff;
      shift_cur = item.frame_start ? SHIFT_RESET : shift_ff;
      err_cur   = item.frame_start ? 1'b0 : err_ff;
      shift_new = shift_cur;
      err_new   = err_cur;
      if (cnt_cur == CNT_HDR_SPACE) begin
         if (!in_window(item.duration, windows.hdr_space_min, windows.hdr_space_max)) begin
            err_new = 1'b1;
         end
      end else if (cnt_cur inside {[CNT_FIRST_BIT:CNT_LAST_CHK]}) begin
         if (cnt_cur[0]) begin
            if (!in_window(item.duration, windows.bit_mark_min, windows.bit_mark_max)) begin
               err_new = 1'b1;
            end
         end else if (in_window(item.duration, windows.one_space_min,
                                windows.one_space_max)) begin
            shift_new = {shift_cur[CMD_W-2:0], 1'b1};
         end else if (in_window(item.duration, windows.zero_space_min,
                                windows.zero_space_max)) begin
            shift_new = {shift_cur[CMD_W-2:0], 1'b0};
         end else begin
            err_new = 1'b1;
         end
      end
      cnt_new = (cnt_cur < CNT_FRAME_MIN) ? cnt_cur + CNT_W'(1) : cnt_cur;
      ok_new  = !err_new && (cnt_new >= CNT_FRAME_MIN);
   end

   always_comb begin
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      err_in   = err_ff;
      if (advance) begin
         if (item.frame_end) begin
            cnt_in   = '0;
            shift_in = SHIFT_RESET;
            err_in   = 1'b0;
         end else begin
            cnt_in   = cnt_new;
            shift_in = shift_new;
            err_in   = err_new;
         end
      end
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         shift_ff     <= SHIFT_RESET;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ok_ff  <= ok_new;
         out_cmd_ff <= ok_new ? shift_new : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_decoded_ok = out_ok_ff;
   assign rsp_command    = out_cmd_ff;

endmodule

>>> design/pulse_distance_ir_decoder_top.sv
// A frame's last item passes the input register and then sets the result register.
// Throughput: one item per cycle, set by the input register feeding the decoder;
// while a result waits to be taken, only a frame's last item is held at the input.
// Synchronous reset clears the frame state and restores the default windows.
// ----------------------------------------------------------------------------
// pulse_distance_ir_decoder_top
// Decodes pulse-distance IR frames from captured mark and space durations.
// ----------------------------------------------------------------------------
module pulse_distance_ir_decoder_top
   import pdird_pkg::*;
#(
   parameter int NUM_BITS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DUR_W-1:0]      req_duration,
   input  logic                  req_frame_start,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_decoded_ok,
   output logic [CMD_W-1:0]      rsp_command,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pdird_windows_type windows;
   pdird_item_type    item;
   logic              item_valid;
   logic              advance;

   pdird_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .windows   (windows)
   );

   pdird_input_stage u_input (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_duration    (req_duration),
      .req_frame_start (req_frame_start),
      .req_frame_end   (req_frame_end),
      .advance         (advance),
      .item_valid      (item_valid),
      .item            (item)
   );

   pdird_core #(
      .NUM_BITS (NUM_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .windows        (windows),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_decoded_ok (rsp_decoded_ok),
      .rsp_command    (rsp_command)
   );

endmodule

>>> design/pdird_checker.sv
// ----------------------------------------------------------------------------
// pdird_checker
// Port-level checks of the IR decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pdird_checker
   import pdird_pkg::*;
#(
   parameter int NUM_BITS = 8
)
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_decoded_ok,
   input logic [CMD_W-1:0] rsp_command
);

   localparam bit LEAD_VISIBLE = (NUM_BITS <= CMD_W);
   localparam int LEAD_POS     = LEAD_VISIBLE ? NUM_BITS - 1 : 0;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command)
         && $stable(rsp_decoded_ok))
      else $error("Stalled item changed or vanished.");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Item offered right after reset.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_decoded_ok |-> rsp_command == '0)
      else $error("Failed frame carries a nonzero command.");

   a_lead_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decoded_ok && LEAD_VISIBLE |->
         (int'(rsp_command) >> LEAD_POS) == 1)
      else $error("Decoded command lacks its leading one.");

endmodule

bind pulse_distance_ir_decoder_top pdird_checker #(
   .NUM_BITS (NUM_BITS)
) u_pdird_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_decoded_ok (rsp_decoded_ok),
   .rsp_command    (rsp_command)
);
